[design/fsh_pkg.sv]
`timescale 1ns / 1ps

package fsh_pkg;

  // Default list depth
  localparam int TOP_COUNT_DEF = 10;

  // Field widths
  localparam int ID_W       = 32;
  localparam int SIZE_W     = 64;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int TABLE_W    = 3;
  localparam int READ_IDX_W = 4;
  localparam int SBIN_W     = 3;
  localparam int ABIN_W     = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  localparam int NUM_SIZE_BINS = 5;
  localparam int NUM_AGE_BINS  = 4;

  // Size bin edges, bytes
  localparam logic [SIZE_W-1:0] SIZE_1KB   = SIZE_W'(64'd1024);
  localparam logic [SIZE_W-1:0] SIZE_1MB   = SIZE_W'(64'd1024 * 64'd1024);
  localparam logic [SIZE_W-1:0] SIZE_100MB = SIZE_W'(64'd100 * 64'd1024 * 64'd1024);
  localparam logic [SIZE_W-1:0] SIZE_1GB   = SIZE_W'(64'd1024 * 64'd1024 * 64'd1024);

  // Age bin edges, seconds
  localparam logic [TIME_W-1:0] AGE_DAY   = TIME_W'(32'd24 * 32'd3600);
  localparam logic [TIME_W-1:0] AGE_WEEK  = TIME_W'(32'd24 * 32'd7 * 32'd3600);
  localparam logic [TIME_W-1:0] AGE_MONTH = TIME_W'(32'd24 * 32'd30 * 32'd3600);

  // Config register byte address (min_size); the full address is compared
  localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_SIZE = CFG_ADDR_W'(0);

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [TABLE_W-1:0] {
    TBL_SIZE_BINS = 3'd0,
    TBL_AGE_BINS  = 3'd1,
    TBL_LARGEST   = 3'd2,
    TBL_OLDEST    = 3'd3,
    TBL_NEWEST    = 3'd4,
    TBL_TOTALS    = 3'd5
  } tbl_t;

  // Totals read index
  localparam logic [READ_IDX_W-1:0] TOT_COUNT = READ_IDX_W'(0);
  localparam logic [READ_IDX_W-1:0] TOT_BYTES = READ_IDX_W'(1);

endpackage

[design/fsh_topk_list.sv]
`timescale 1ns / 1ps

module fsh_topk_list #(
  parameter int TOP_COUNT = fsh_pkg::TOP_COUNT_DEF,
  parameter int KEY_W     = fsh_pkg::SIZE_W,
  parameter bit WANT_LOW  = 1'b0,
  parameter int FILL_W    = $clog2(TOP_COUNT + 1)
) (
  input  logic                          clk,
  input  logic                          ins_en,
  input  logic [FILL_W-1:0]             fill,
  input  logic [fsh_pkg::ID_W-1:0]      ins_id,
  input  logic [KEY_W-1:0]              ins_key,
  input  logic [fsh_pkg::READ_IDX_W-1:0] rd_idx,
  output logic [fsh_pkg::ID_W-1:0]      rd_id,
  output logic [KEY_W-1:0]              rd_key
);

  import fsh_pkg::*;

  logic [ID_W-1:0]  ids_r  [TOP_COUNT];
  logic [KEY_W-1:0] keys_r [TOP_COUNT];

  // moves[k]: slot k takes the new entry or its upper neighbor.
  // Sorted list makes this a suffix; its first bit is the insert point.
  logic [TOP_COUNT-1:0] moves;

  genvar g;
  generate
    for (g = 0; g < TOP_COUNT; g++) begin : g_slot
      logic beats;
      assign beats = WANT_LOW ? (ins_key < keys_r[g]) : (ins_key > keys_r[g]);
      assign moves[g] = (FILL_W'(g) < fill) ? beats : 1'b1;
    end
  endgenerate

  // Slot 0 can only take the new entry; any other slot takes the new entry
  // at the insert point and its upper neighbor past it.
  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (moves[0]) begin
        ids_r[0]  <= ins_id;
        keys_r[0] <= ins_key;
      end
      for (int k = 1; k < TOP_COUNT; k++) begin
        if (moves[k]) begin
          if (!moves[k-1]) begin
            ids_r[k]  <= ins_id;
            keys_r[k] <= ins_key;
          end else begin
            ids_r[k]  <= ids_r[k-1];
            keys_r[k] <= keys_r[k-1];
          end
        end
      end
    end
  end

  always_comb begin
    rd_id  = '0;
    rd_key = '0;
    for (int k = 0; k < TOP_COUNT; k++) begin
      if (32'(rd_idx) == k) begin
        rd_id  = ids_r[k];
        rd_key = keys_r[k];
      end
    end
  end

endmodule

[design/file_stats_histogram_topk_top.sv]
`timescale 1ns / 1ps

// Streaming file statistics. Each input transaction either records one file
// (size, mtime, current time, id) or reads one statistic back. Records below
// min_size are dropped; the rest bump file count, byte total, one of five size
// bins and one of four age bins, and are offered to three sorted top lists
// (largest size, oldest mtime, newest mtime) of TOP_COUNT entries. A full list
// only admits a strictly better key; equal keys land behind existing ones.
// Pipeline: input register -> bin/insert/read logic -> output register.
// Sustained rate is one transaction per cycle while out_stall is low. A
// transaction passes from the input register to the output register, which
// raises out_valid; an output stall holds both stages and then stalls the
// input. The insert compares and shifts the new entry across all TOP_COUNT
// list slots in parallel.
// Reads see every earlier transaction. Each transaction yields exactly one
// result. min_size sits at APB address 0 (64-bit data); write it only while
// the block is idle. List slots never written read as invalid.

module file_stats_histogram_topk_top #(
  parameter int TOP_COUNT = fsh_pkg::TOP_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  // APB-style config
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fsh_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fsh_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fsh_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,

  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [fsh_pkg::ID_W-1:0]        in_file_id,
  input  logic [fsh_pkg::SIZE_W-1:0]      in_file_size,
  input  logic [fsh_pkg::TIME_W-1:0]      in_modified_time,
  input  logic [fsh_pkg::TIME_W-1:0]      in_current_time,
  input  logic [fsh_pkg::TABLE_W-1:0]     in_read_table,
  input  logic [fsh_pkg::READ_IDX_W-1:0]  in_read_index,

  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [fsh_pkg::SBIN_W-1:0]      out_size_bin,
  output logic [fsh_pkg::ABIN_W-1:0]      out_age_bin,
  output logic                            out_read_valid,
  output logic [fsh_pkg::ID_W-1:0]        out_read_id,
  output logic [fsh_pkg::SIZE_W-1:0]      out_read_value
);

  import fsh_pkg::*;

  localparam int FILL_W = $clog2(TOP_COUNT + 1);
  // Width that holds both a read index and the fill count
  localparam int CMP_W  = (FILL_W > READ_IDX_W) ? FILL_W : READ_IDX_W;

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] min_size_r;
  logic              cfg_wr;
  logic              cfg_hit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (paddr == ADDR_MIN_SIZE);
  assign prdata  = cfg_hit ? min_size_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r <= '0;
    end else if (cfg_wr && cfg_hit) begin
      min_size_r <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [ID_W-1:0]       s1_id_r;
  logic [SIZE_W-1:0]     s1_size_r;
  logic [TIME_W-1:0]     s1_mtime_r;
  logic [TIME_W-1:0]     s1_now_r;
  logic [TABLE_W-1:0]    s1_table_r;
  logic [READ_IDX_W-1:0] s1_idx_r;

  logic s1_fire;   // stage 1 hands its transaction to the output register
  logic in_fire;

  assign s1_fire  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_operation;
      s1_id_r    <= in_file_id;
      s1_size_r  <= in_file_size;
      s1_mtime_r <= in_modified_time;
      s1_now_r   <= in_current_time;
      s1_table_r <= in_read_table;
      s1_idx_r   <= in_read_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Record path: threshold and bins
  // ---------------------------------------------------------------------------
  logic              is_read;
  logic              rec_ok;     // record passes threshold
  logic              rec_upd;    // commit state this cycle
  logic [SBIN_W-1:0] sbin;
  logic [ABIN_W-1:0] abin;
  logic [TIME_W-1:0] age;

  assign is_read = (op_t'(s1_op_r) == OP_READ);
  assign rec_ok  = !is_read && (s1_size_r >= min_size_r);
  assign rec_upd = s1_fire && rec_ok;
  assign age     = s1_now_r - s1_mtime_r;

  always_comb begin
    if (s1_size_r < SIZE_1KB)        sbin = SBIN_W'(0);
    else if (s1_size_r < SIZE_1MB)   sbin = SBIN_W'(1);
    else if (s1_size_r < SIZE_100MB) sbin = SBIN_W'(2);
    else if (s1_size_r < SIZE_1GB)   sbin = SBIN_W'(3);
    else                             sbin = SBIN_W'(4);

    // mtime in the future counts as fresh
    if (s1_mtime_r > s1_now_r)       abin = ABIN_W'(0);
    else if (age < AGE_DAY)          abin = ABIN_W'(0);
    else if (age < AGE_WEEK)         abin = ABIN_W'(1);
    else if (age < AGE_MONTH)        abin = ABIN_W'(2);
    else                             abin = ABIN_W'(3);
  end

  // ---------------------------------------------------------------------------
  // Counters
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  size_cnt_r [NUM_SIZE_BINS];
  logic [CNT_W-1:0]  age_cnt_r  [NUM_AGE_BINS];
  logic [CNT_W-1:0]  file_count_r;
  logic [SIZE_W-1:0] byte_total_r;
  logic [FILL_W-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_SIZE_BINS; b++) size_cnt_r[b] <= '0;
      for (int b = 0; b < NUM_AGE_BINS; b++)  age_cnt_r[b]  <= '0;
      file_count_r <= '0;
      byte_total_r <= '0;
      fill_r       <= '0;
    end else if (rec_upd) begin
      for (int b = 0; b < NUM_SIZE_BINS; b++) begin
        if (sbin == SBIN_W'(b)) size_cnt_r[b] <= size_cnt_r[b] + CNT_W'(1);
      end
      for (int b = 0; b < NUM_AGE_BINS; b++) begin
        if (abin == ABIN_W'(b)) age_cnt_r[b] <= age_cnt_r[b] + CNT_W'(1);
      end
      file_count_r <= file_count_r + CNT_W'(1);
      byte_total_r <= byte_total_r + s1_size_r;
      if (fill_r < FILL_W'(TOP_COUNT)) fill_r <= fill_r + FILL_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Top lists
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   lg_id, old_id, new_id;
  logic [SIZE_W-1:0] lg_key;
  logic [TIME_W-1:0] old_key, new_key;

  fsh_topk_list #(
    .TOP_COUNT (TOP_COUNT),
    .KEY_W     (SIZE_W),
    .WANT_LOW  (1'b0),
    .FILL_W    (FILL_W)
  ) u_largest (
    .clk     (clk),
    .ins_en  (rec_upd),
    .fill    (fill_r),
    .ins_id  (s1_id_r),
    .ins_key (s1_size_r),
    .rd_idx  (s1_idx_r),
    .rd_id   (lg_id),
    .rd_key  (lg_key)
  );

  fsh_topk_list #(
    .TOP_COUNT (TOP_COUNT),
    .KEY_W     (TIME_W),
    .WANT_LOW  (1'b1),
    .FILL_W    (FILL_W)
  ) u_oldest (
    .clk     (clk),
    .ins_en  (rec_upd),
    .fill    (fill_r),
    .ins_id  (s1_id_r),
    .ins_key (s1_mtime_r),
    .rd_idx  (s1_idx_r),
    .rd_id   (old_id),
    .rd_key  (old_key)
  );

  fsh_topk_list #(
    .TOP_COUNT (TOP_COUNT),
    .KEY_W     (TIME_W),
    .WANT_LOW  (1'b0),
    .FILL_W    (FILL_W)
  ) u_newest (
    .clk     (clk),
    .ins_en  (rec_upd),
    .fill    (fill_r),
    .ins_id  (s1_id_r),
    .ins_key (s1_mtime_r),
    .rd_idx  (s1_idx_r),
    .rd_id   (new_id),
    .rd_key  (new_key)
  );

  // ---------------------------------------------------------------------------
  // Read mux
  // ---------------------------------------------------------------------------
  logic              rank_ok;
  logic              rd_valid;
  logic [ID_W-1:0]   rd_id;
  logic [SIZE_W-1:0] rd_value;

  assign rank_ok = (CMP_W'(s1_idx_r) < CMP_W'(fill_r));

  always_comb begin
    rd_valid = 1'b0;
    rd_id    = '0;
    rd_value = '0;
    unique case (tbl_t'(s1_table_r))
      TBL_SIZE_BINS: begin
        if (s1_idx_r < READ_IDX_W'(NUM_SIZE_BINS)) begin
          rd_valid = 1'b1;
          rd_value = SIZE_W'(size_cnt_r[s1_idx_r[2:0]]);
        end
      end
      TBL_AGE_BINS: begin
        if (s1_idx_r < READ_IDX_W'(NUM_AGE_BINS)) begin
          rd_valid = 1'b1;
          rd_value = SIZE_W'(age_cnt_r[s1_idx_r[1:0]]);
        end
      end
      TBL_LARGEST: begin
        if (rank_ok) begin
          rd_valid = 1'b1;
          rd_id    = lg_id;
          rd_value = lg_key;
        end
      end
      TBL_OLDEST: begin
        if (rank_ok) begin
          rd_valid = 1'b1;
          rd_id    = old_id;
          rd_value = SIZE_W'(old_key);
        end
      end
      TBL_NEWEST: begin
        if (rank_ok) begin
          rd_valid = 1'b1;
          rd_id    = new_id;
          rd_value = SIZE_W'(new_key);
        end
      end
      TBL_TOTALS: begin
        if (s1_idx_r == TOT_COUNT) begin
          rd_valid = 1'b1;
          rd_value = SIZE_W'(file_count_r);
        end else if (s1_idx_r == TOT_BYTES) begin
          rd_valid = 1'b1;
          rd_value = byte_total_r;
        end
      end
      default: begin
        rd_valid = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_r;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_accepted   <= rec_ok;
      out_size_bin   <= rec_ok ? sbin : '0;
      out_age_bin    <= rec_ok ? abin : '0;
      out_read_valid <= is_read && rd_valid;
      out_read_id    <= is_read ? rd_id : '0;
      out_read_value <= is_read ? rd_value : '0;
    end
  end

endmodule
